// ===== rtl/fpcc_pkg.sv =====
package fpcc_pkg;

    localparam int SIZE_LOG2 = 20;
    localparam int ADDR_W    = SIZE_LOG2;
    localparam int BUS_ADDR_W = 24;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [ADDR_W-1:0] PAGE_BASE_MASK = ~ADDR_W'(20'h0FFFF);

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_LOAD  = 2'd2
    } kind_t;

    localparam logic [7:0] MODE_STATUS     = 8'h70;
    localparam logic [7:0] MODE_EXT_STATUS = 8'h71;
    localparam logic [7:0] MODE_IDENT      = 8'h75;
    localparam logic [7:0] MODE_PROG_A     = 8'h10;
    localparam logic [7:0] MODE_PROG_B     = 8'h40;
    localparam logic [7:0] MODE_PAGE_ERASE = 8'h20;
    localparam logic [7:0] MODE_CHIP_ERASE = 8'hA7;

    localparam logic [7:0] STATUS_READY = 8'h80;
    localparam logic [7:0] EXT_STATUS_4 = 8'h87;
    localparam logic [7:0] ID_MAKER     = 8'h4D;
    localparam logic [7:0] ID_DEVICE    = 8'h50;
    localparam logic [7:0] ID_BYTE4     = 8'h04;
    localparam logic [7:0] ERASED_BYTE  = 8'hFF;
    localparam logic [3:0] SIZE_CODE    = 4'(SIZE_LOG2 - 10);
    localparam logic [3:0] PACK_NO_CHIP_ERASE = 4'd3;

    localparam logic [CFG_IDX_W-1:0] REG_QUERYABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FLASHABLE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PACK_TYPE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FILLER    = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_READ       = 3'd1,
        ACT_LOAD       = 3'd2,
        ACT_PROGRAM    = 3'd3,
        ACT_PAGE_ERASE = 3'd4,
        ACT_CHIP_ERASE = 3'd5,
        ACT_LATCH      = 3'd6
    } action_t;

    typedef struct packed {
        logic capture;
        logic mem_read;
        logic load_write;
        logic prog_write;
        logic sweep_init;
        logic sweep_write;
        logic latch_mode;
        logic set_status;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    sweep_last;
        logic    out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/fpcc_if.sv =====
interface fpcc_in_if;
    import fpcc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [BUS_ADDR_W-1:0] address;
    logic [7:0]            bus_data;
    modport source (output valid, kind, address, bus_data, input ready);
    modport sink (input valid, kind, address, bus_data, output ready);
endinterface

interface fpcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface

interface fpcc_cfg_if;
    import fpcc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/fpcc_ctrl.sv =====
module fpcc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  fpcc_pkg::ctrl_sts_t sts,
    output fpcc_pkg::ctrl_cmd_t cmd
);
    import fpcc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_READ   = 5'b00100,
        ST_PROG   = 5'b01000,
        ST_ERASE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (sts.action)
                    ACT_READ:
                    begin
                        cmd.mem_read = 1'b1;
                        state_next = ST_READ;
                    end
                    ACT_PROGRAM:
                    begin
                        cmd.mem_read = 1'b1;
                        state_next = ST_PROG;
                    end
                    ACT_LOAD:
                    begin
                        cmd.load_write = 1'b1;
                        state_next = ST_IDLE;
                    end
                    ACT_PAGE_ERASE, ACT_CHIP_ERASE:
                    begin
                        cmd.sweep_init = 1'b1;
                        state_next = ST_ERASE;
                    end
                    ACT_LATCH:
                    begin
                        cmd.latch_mode = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ:
            begin
                // hold the fetched byte until the result slot frees up
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PROG:
            begin
                cmd.prog_write = 1'b1;
                cmd.set_status = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ERASE:
            begin
                cmd.sweep_write = 1'b1;
                if (sts.sweep_last)
                begin
                    cmd.set_status = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result slot overwritten");

    a_prog_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prog_write |-> $past(cmd.mem_read))
        else $error("program write without prior array read");

    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_write && sts.sweep_last) |=> (state_reg == ST_IDLE))
        else $error("erase sweep did not finish");

endmodule

// ===== rtl/fpcc_datapath.sv =====
module fpcc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fpcc_pkg::ctrl_cmd_t                 cmd,
    output fpcc_pkg::ctrl_sts_t                 sts,
    input  logic [1:0]                          in_kind,
    input  logic [fpcc_pkg::BUS_ADDR_W-1:0]     in_address,
    input  logic [7:0]                          in_bus_data,
    fpcc_cfg_if.sink                            cfg,
    fpcc_out_if.source                          result
);
    import fpcc_pkg::*;

    logic [7:0]        flash_array [2**SIZE_LOG2];

    logic              queryable_reg;
    logic              flashable_reg;
    logic [3:0]        pack_type_reg;
    logic [7:0]        filler_reg;
    logic [7:0]        command_mode_reg;
    logic              result_valid_reg;

    kind_t             kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        data_reg;
    logic [7:0]        rdata_reg;
    logic [7:0]        read_data_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic              sweep_chip_reg;

    action_t           action;
    logic [7:0]        read_sel;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic              prog_mode;

    assign prog_mode = (command_mode_reg == MODE_PROG_A) || (command_mode_reg == MODE_PROG_B);

    always_comb
    begin
        action = ACT_NONE;
        unique case (kind_reg)
            KIND_READ:
            begin
                action = ACT_READ;
            end
            KIND_LOAD:
            begin
                action = ACT_LOAD;
            end
            KIND_WRITE:
            begin
                priority if (!queryable_reg)
                    action = ACT_NONE;
                else if (prog_mode)
                    action = flashable_reg ? ACT_PROGRAM : ACT_NONE;
                else if (command_mode_reg == MODE_PAGE_ERASE)
                    action = ACT_PAGE_ERASE;
                else if (command_mode_reg == MODE_CHIP_ERASE)
                    action = (pack_type_reg == PACK_NO_CHIP_ERASE) ? ACT_NONE : ACT_CHIP_ERASE;
                else if (addr_reg[15:0] == 16'h0000)
                    action = ACT_LATCH;
                else
                    action = ACT_NONE;
            end
            default:
            begin
                action = ACT_NONE;
            end
        endcase
    end

    assign sts.action     = action;
    assign sts.sweep_last = sweep_chip_reg ? (&sweep_reg) : (&sweep_reg[15:0]);
    assign sts.out_free   = !result_valid_reg || result.ready;

    always_comb
    begin
        priority if (!queryable_reg)
            read_sel = rdata_reg;
        else if (command_mode_reg == MODE_STATUS)
            read_sel = STATUS_READY;
        else if (command_mode_reg == MODE_EXT_STATUS)
        begin
            priority if (addr_reg[15:0] == 16'h0002)
                read_sel = STATUS_READY;
            else if (addr_reg[15:0] == 16'h0004)
                read_sel = EXT_STATUS_4;
            else
                read_sel = 8'h00;
        end
        else if (command_mode_reg == MODE_IDENT)
        begin
            unique case (addr_reg[7:0])
                8'h00:   read_sel = ID_MAKER;
                8'h02:   read_sel = ID_DEVICE;
                8'h04:   read_sel = ID_BYTE4;
                8'h06:   read_sel = {pack_type_reg, SIZE_CODE};
                default: read_sel = filler_reg;
            endcase
        end
        else
            read_sel = rdata_reg;
    end

    // single array port: sweep, program write-back or image load
    assign mem_we    = cmd.sweep_write || cmd.prog_write || cmd.load_write;
    assign mem_addr  = cmd.sweep_write ? sweep_reg : addr_reg;
    always_comb
    begin
        priority if (cmd.sweep_write)
            mem_wdata = ERASED_BYTE;
        else if (cmd.prog_write)
            mem_wdata = rdata_reg & data_reg;
        else
            mem_wdata = data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            flash_array[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= flash_array[mem_addr];
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queryable_reg    <= 1'b1;
            flashable_reg    <= 1'b1;
            pack_type_reg    <= 4'd1;
            filler_reg       <= 8'h00;
            command_mode_reg <= 8'h00;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_QUERYABLE: queryable_reg <= cfg.data[0];
                    REG_FLASHABLE: flashable_reg <= cfg.data[0];
                    REG_PACK_TYPE: pack_type_reg <= cfg.data[3:0];
                    REG_FILLER:    filler_reg    <= cfg.data;
                    default:       ;
                endcase
            end
            if (cmd.latch_mode)
            begin
                command_mode_reg <= data_reg;
            end
            else if (cmd.set_status)
            begin
                command_mode_reg <= MODE_STATUS;
            end
            if (cmd.load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(in_kind);
            addr_reg <= in_address[ADDR_W-1:0];
            data_reg <= in_bus_data;
        end
        if (cmd.sweep_init)
        begin
            sweep_chip_reg <= (action == ACT_CHIP_ERASE);
            sweep_reg      <= (action == ACT_CHIP_ERASE) ? '0 : (addr_reg & PAGE_BASE_MASK);
        end
        else if (cmd.sweep_write)
        begin
            sweep_reg <= sweep_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            read_data_reg <= read_sel;
        end
    end

    assign result.valid     = result_valid_reg;
    assign result.read_data = read_data_reg;

    a_mode_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(command_mode_reg) |-> $past(cmd.latch_mode || cmd.set_status))
        else $error("command mode changed without a command");

    a_sweep_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_write && !sts.sweep_last) |=> (sweep_reg == $past(sweep_reg) + 1'b1))
        else $error("erase sweep skipped an address");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> result_valid_reg)
        else $error("result not presented after load");

endmodule

// ===== rtl/flash_pack_command_controller_top.sv =====
// channel  | role | payload
// item     | sink | kind, address, bus_data
// result   | src  | read_data
// cfg      | sink | index, data (always ready)
//
// a write or image load is captured then decoded; a read adds array fetch, then result load
// a program does an array read, then a write-back on the single array port
// page erase sweeps 65536 bytes, chip erase 2**SIZE_LOG2 bytes, one byte per cycle
// item ready only while the controller is idle; a read waits while the result is not taken
// reset sets the mode to zero and the config registers to their defaults;
// array contents are undefined until loaded or erased
module flash_pack_command_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    fpcc_in_if.sink     item,
    fpcc_out_if.source  result,
    fpcc_cfg_if.sink    cfg
);
    import fpcc_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      item_ready;

    assign item.ready = item_ready;

    fpcc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    fpcc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_kind     (item.kind),
        .in_address  (item.address),
        .in_bus_data (item.bus_data),
        .cfg         (cfg),
        .result      (result)
    );

endmodule

// ===== tb/tb_flash_pack_command_controller_top.sv =====
`timescale 1ns / 100ps

module tb_flash_pack_command_controller_top;
    import fpcc_pkg::*;

    localparam logic [1:0] KIND_UNUSED     = 2'd3;
    localparam logic [7:0] MODE_READ_ARRAY = 8'hFF;
    localparam int         STORE_BYTES     = 1 << SIZE_LOG2;
    localparam int         PAGE_BYTES      = 65536;

    typedef struct packed {
        logic [1:0]            kind;
        logic [BUS_ADDR_W-1:0] addr;
        logic [7:0]            data;
        logic                  pinned;
        logic [7:0]            want;
    } dir_row_t;

    // opening sequence; pinned rows carry a hand-typed read value
    localparam int DIR_ROWS_N = 28;
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{KIND_LOAD,   24'h000123, 8'hFF,           1'b0, 8'h00},
        '{KIND_LOAD,   24'hFFFFFF, 8'h00,           1'b0, 8'h00},
        '{KIND_READ,   24'h000123, 8'h00,           1'b1, 8'hFF},
        '{KIND_READ,   24'hFFFFFF, 8'hFF,           1'b1, 8'h00},
        '{KIND_WRITE,  24'h000000, MODE_STATUS,     1'b0, 8'h00},
        '{KIND_READ,   24'h000005, 8'h00,           1'b1, STATUS_READY},
        '{KIND_WRITE,  24'h000000, MODE_EXT_STATUS, 1'b0, 8'h00},
        '{KIND_READ,   24'h000002, 8'h00,           1'b1, STATUS_READY},
        '{KIND_READ,   24'h000004, 8'h00,           1'b1, EXT_STATUS_4},
        '{KIND_WRITE,  24'h000000, MODE_IDENT,      1'b0, 8'h00},
        '{KIND_READ,   24'h000000, 8'h00,           1'b1, ID_MAKER},
        '{KIND_READ,   24'h000002, 8'h00,           1'b1, ID_DEVICE},
        '{KIND_READ,   24'h000004, 8'h00,           1'b1, ID_BYTE4},
        '{KIND_READ,   24'h000006, 8'h00,           1'b0, 8'h00},
        '{KIND_READ,   24'h0000FF, 8'h00,           1'b1, 8'h00},
        '{KIND_WRITE,  24'h000000, MODE_PROG_B,     1'b0, 8'h00},
        '{KIND_WRITE,  24'h000123, 8'h0F,           1'b0, 8'h00},
        '{KIND_WRITE,  24'h000000, MODE_READ_ARRAY, 1'b0, 8'h00},
        '{KIND_READ,   24'h000123, 8'h00,           1'b1, 8'h0F},
        '{KIND_UNUSED, 24'h000123, 8'hAA,           1'b0, 8'h00},
        '{KIND_READ,   24'h000123, 8'h00,           1'b1, 8'h0F},
        '{KIND_WRITE,  24'h000000, MODE_PAGE_ERASE, 1'b0, 8'h00},
        '{KIND_WRITE,  24'h0F1234, 8'h00,           1'b0, 8'h00},
        '{KIND_WRITE,  24'h000000, MODE_CHIP_ERASE, 1'b0, 8'h00},
        '{KIND_WRITE,  24'h00ABCD, 8'hFF,           1'b0, 8'h00},
        '{KIND_READ,   24'h000000, 8'h00,           1'b1, STATUS_READY},
        '{KIND_WRITE,  24'h000000, MODE_READ_ARRAY, 1'b0, 8'h00},
        '{KIND_READ,   24'hFFFFFF, 8'h00,           1'b1, ERASED_BYTE}
    };

    logic clk;
    logic rst_n;

    fpcc_in_if  item_bus ();
    fpcc_out_if read_bus ();
    fpcc_cfg_if cfg_bus ();

    flash_pack_command_controller_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (read_bus),
        .cfg    (cfg_bus)
    );

    // shadow of the flash pack
    logic [7:0] flash_img [STORE_BYTES];
    logic [7:0] cmd_mode;
    bit         query_on;
    bit         flash_on;
    logic [3:0] pack_code;
    logic [7:0] filler_val;

    logic [7:0] expected_reads [$];

    int items_sent;
    int reads_checked;
    int mismatches;
    int erase_budget;
    int page_erases;
    int chip_erases;
    int hold_left;
    bit src_idling;
    bit sink_idling;
    bit idling_allowed;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #150_000_000;
        $display("tb_flash_pack_command_controller_top: errors");
        $finish;
    end

    function automatic logic [7:0] flash_read_byte(input logic [ADDR_W-1:0] a);
        if (!query_on)
            return flash_img[a];
        case (cmd_mode)
            MODE_STATUS:
                return STATUS_READY;
            MODE_EXT_STATUS:
            begin
                if (a[15:0] == 16'd2)
                    return STATUS_READY;
                if (a[15:0] == 16'd4)
                    return EXT_STATUS_4;
                return 8'h00;
            end
            MODE_IDENT:
            begin
                case (a[7:0])
                    8'd0:    return ID_MAKER;
                    8'd2:    return ID_DEVICE;
                    8'd4:    return ID_BYTE4;
                    8'd6:    return {pack_code, SIZE_CODE};
                    default: return filler_val;
                endcase
            end
            default:
                return flash_img[a];
        endcase
    endfunction

    task automatic flash_bus_write(input logic [ADDR_W-1:0] a, input logic [7:0] d);
        logic [ADDR_W-1:0] base;
        int i;
        if (!query_on)
            return;
        if (cmd_mode == MODE_PROG_A || cmd_mode == MODE_PROG_B)
        begin
            // refused program leaves the mode where it is
            if (flash_on)
            begin
                flash_img[a] = flash_img[a] & d;
                cmd_mode = MODE_STATUS;
            end
        end
        else if (cmd_mode == MODE_PAGE_ERASE)
        begin
            base = a & PAGE_BASE_MASK;
            for (i = 0; i < PAGE_BYTES; i++)
                flash_img[base | ADDR_W'(i)] = ERASED_BYTE;
            cmd_mode = MODE_STATUS;
            page_erases++;
        end
        else if (cmd_mode == MODE_CHIP_ERASE)
        begin
            if (pack_code != PACK_NO_CHIP_ERASE)
            begin
                for (i = 0; i < STORE_BYTES; i++)
                    flash_img[i] = ERASED_BYTE;
                cmd_mode = MODE_STATUS;
                chip_erases++;
            end
        end
        else if (a[15:0] == 16'h0000)
        begin
            cmd_mode = d;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // caller is at a rising edge; valid stays high after the transfer
    task automatic send(input logic [1:0] k, input logic [BUS_ADDR_W-1:0] a,
                        input logic [7:0] d, input bit pinned, input logic [7:0] want);
        item_bus.valid    <= 1'b1;
        item_bus.kind     <= k;
        item_bus.address  <= a;
        item_bus.bus_data <= d;
        do @(posedge clk); while (!item_bus.ready);
        case (k)
            KIND_READ:
                expected_reads.push_back(pinned ? want : flash_read_byte(a[ADDR_W-1:0]));
            KIND_WRITE:
                flash_bus_write(a[ADDR_W-1:0], d);
            KIND_LOAD:
                flash_img[a[ADDR_W-1:0]] = d;
            default:
                ;
        endcase
        if (k != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic pace();
        if (idling_allowed && $urandom_range(0, 31) == 0)
        begin
            src_idling  = 1'($urandom_range(0, 1));
            sink_idling = 1'($urandom_range(0, 1));
        end
        if (src_idling && $urandom_range(0, 3) == 0)
        begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // keeps random traffic away from chip erase and bounds the page erases
    task automatic send_rand(input logic [1:0] k, input logic [BUS_ADDR_W-1:0] a,
                             input logic [7:0] d);
        pace();
        if (k == KIND_WRITE && query_on && a[15:0] == 16'h0000
            && cmd_mode != MODE_PROG_A && cmd_mode != MODE_PROG_B
            && cmd_mode != MODE_PAGE_ERASE && cmd_mode != MODE_CHIP_ERASE)
        begin
            if (d == MODE_CHIP_ERASE || (d == MODE_PAGE_ERASE && erase_budget == 0))
                d = MODE_READ_ARRAY;
            else if (d == MODE_PAGE_ERASE)
                erase_budget--;
        end
        send(k, a, d, 1'b0, 8'h00);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] v);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= v;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            REG_QUERYABLE: query_on   = v[0];
            REG_FLASHABLE: flash_on   = v[0];
            REG_PACK_TYPE: pack_code  = v[3:0];
            REG_FILLER:    filler_val = v[7:0];
            default:       ;
        endcase
    endtask

    task automatic set_pins(input bit q, input bit f, input logic [3:0] pack,
                            input logic [7:0] filler);
        write_reg(REG_QUERYABLE, CFG_DATA_W'(q));
        write_reg(REG_FLASHABLE, CFG_DATA_W'(f));
        write_reg(REG_PACK_TYPE, CFG_DATA_W'(pack));
        write_reg(REG_FILLER, CFG_DATA_W'(filler));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain();
        item_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_reads.size() != 0);
    endtask

    function automatic logic [BUS_ADDR_W-1:0] cmd_addr();
        return {8'($urandom), 16'h0000};
    endfunction

    function automatic logic [BUS_ADDR_W-1:0] probe_addr();
        logic [7:0] low;
        case ($urandom_range(0, 4))
            0:       low = 8'h00;
            1:       low = 8'h02;
            2:       low = 8'h04;
            3:       low = 8'h06;
            default: low = 8'($urandom);
        endcase
        if ($urandom_range(0, 1))
            return {8'($urandom), 8'h00, low};
        return {16'($urandom), low};
    endfunction

    // leaves program mode if flash_on; ends on a read so no erase can still run
    task automatic close_phase();
        send_rand(KIND_WRITE, cmd_addr(), MODE_READ_ARRAY);
        send_rand(KIND_READ, probe_addr(), 8'($urandom));
        drain();
        repeat (8) @(posedge clk);
    endtask

    task automatic run_random(input int quota);
        int start;
        int n;
        int j;
        logic [7:0] cmd;
        logic [BUS_ADDR_W-1:0] a;
        logic [BUS_ADDR_W-1:0] spots [4];
        start = items_sent;
        while (items_sent - start < quota)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    case ($urandom_range(0, 4))
                        0:       cmd = MODE_STATUS;
                        1:       cmd = MODE_EXT_STATUS;
                        2:       cmd = MODE_IDENT;
                        3:       cmd = MODE_READ_ARRAY;
                        default: cmd = 8'($urandom);
                    endcase
                    send_rand(KIND_WRITE, cmd_addr(), cmd);
                    n = $urandom_range(2, 5);
                    for (j = 0; j < n; j++)
                        send_rand(KIND_READ, probe_addr(), 8'($urandom));
                end
                2, 3:
                begin
                    send_rand(KIND_WRITE, cmd_addr(),
                              $urandom_range(0, 1) ? MODE_PROG_A : MODE_PROG_B);
                    a = 24'($urandom);
                    send_rand(KIND_WRITE, a, 8'($urandom));
                    send_rand(KIND_WRITE, cmd_addr(), MODE_READ_ARRAY);
                    send_rand(KIND_READ, a, 8'($urandom));
                end
                4:
                begin
                    send_rand(KIND_WRITE, cmd_addr(), MODE_PAGE_ERASE);
                    send_rand(KIND_WRITE, 24'($urandom), 8'($urandom));
                    send_rand(KIND_READ, probe_addr(), 8'($urandom));
                end
                5, 6:
                begin
                    n = $urandom_range(1, 4);
                    for (j = 0; j < n; j++)
                    begin
                        spots[j] = 24'($urandom);
                        send_rand(KIND_LOAD, spots[j], 8'($urandom));
                    end
                    send_rand(KIND_WRITE, cmd_addr(), MODE_READ_ARRAY);
                    for (j = 0; j < n; j++)
                        send_rand(KIND_READ, spots[j], 8'($urandom));
                end
                default:
                    send_rand(2'($urandom), 24'($urandom), 8'($urandom));
            endcase
        end
    endtask

    // result side: ready drops in bursts while sink idling is on
    initial
    begin
        read_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                read_bus.ready <= 1'b0;
            end
            else if (sink_idling && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 15);
                read_bus.ready <= 1'b0;
            end
            else
            begin
                read_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && read_bus.valid && read_bus.ready)
        begin
            if (expected_reads.size() == 0)
            begin
                report_mismatch($sformatf("read data %02h with no read outstanding",
                                          read_bus.read_data));
            end
            else
            begin
                if (read_bus.read_data !== expected_reads[0])
                    report_mismatch($sformatf("read data %02h, wanted %02h",
                                              read_bus.read_data, expected_reads[0]));
                reads_checked++;
                void'(expected_reads.pop_front());
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        item_bus.valid    <= 1'b0;
        item_bus.kind     <= KIND_READ;
        item_bus.address  <= '0;
        item_bus.bus_data <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= REG_QUERYABLE;
        cfg_bus.data      <= '0;
        cmd_mode       = 8'h00;
        query_on       = 1'b1;
        flash_on       = 1'b1;
        pack_code      = 4'd1;
        filler_val     = 8'h00;
        items_sent     = 0;
        reads_checked  = 0;
        mismatches     = 0;
        erase_budget   = 2;
        page_erases    = 0;
        chip_erases    = 0;
        hold_left      = 0;
        src_idling     = 1'b1;
        sink_idling    = 1'b1;
        idling_allowed = 1'b1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS_N; i++)
        begin
            pace();
            send(DIR_ROWS[i].kind, DIR_ROWS[i].addr, DIR_ROWS[i].data,
                 DIR_ROWS[i].pinned, DIR_ROWS[i].want);
        end
        close_phase();

        set_pins(1'b1, 1'b1, 4'h0, 8'h00);
        run_random(170);
        close_phase();

        // page erase has to go through with the flash pin low
        set_pins(1'b1, 1'b0, 4'hF, 8'hFF);
        send(KIND_WRITE, cmd_addr(), MODE_PAGE_ERASE, 1'b0, 8'h00);
        send(KIND_WRITE, 24'($urandom), 8'($urandom), 1'b0, 8'h00);
        send(KIND_READ, probe_addr(), 8'($urandom), 1'b0, 8'h00);
        run_random(85);
        drain();
        run_random(85);
        close_phase();

        set_pins(1'b0, 1'b1, 4'($urandom), 8'($urandom));
        run_random(170);
        close_phase();

        set_pins(1'b1, 1'b1, 4'($urandom_range(4, 14)), 8'($urandom));
        run_random(170);
        close_phase();

        idling_allowed = 1'b0;
        src_idling     = 1'b0;
        sink_idling    = 1'b0;
        hold_left      = 0;
        set_pins(1'b1, 1'b1, PACK_NO_CHIP_ERASE, 8'($urandom));
        run_random(170);
        // pack type without chip erase: the mode sticks and the store is untouched
        send_rand(KIND_WRITE, cmd_addr(), MODE_READ_ARRAY);
        send(KIND_WRITE, cmd_addr(), MODE_CHIP_ERASE, 1'b0, 8'h00);
        send(KIND_WRITE, 24'($urandom), 8'($urandom), 1'b0, 8'h00);
        send(KIND_READ, probe_addr(), 8'($urandom), 1'b0, 8'h00);

        drain();
        repeat (10) @(posedge clk);

        $display("%0d items, %0d read bytes checked, %0d page erase(s), %0d chip erase(s)",
                 items_sent, reads_checked, page_erases, chip_erases);
        $display("six pin settings incl. pins off, refused program and refused chip erase");
        if (mismatches == 0 && expected_reads.size() == 0)
            $display("tb_flash_pack_command_controller_top: clean");
        else
            $display("tb_flash_pack_command_controller_top: errors");
        $finish;
    end

endmodule
